// ===== src/tdbl_pkg.sv =====
// ============================================================================
// tdbl_pkg: shared types and constants for the tree distance core
// Field widths, transaction structs, operation codes and the node index
// helper used by the sequencer and the table store.
// ============================================================================
`default_nettype none

package tdbl_pkg;

  // Field widths fixed by the item format
  localparam int unsigned NODE_W = 10;
  localparam int unsigned DIST_W = 11;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned ALU_W  = 12;

  // Largest node count a 10-bit node number can reach
  localparam int unsigned NODE_MAX = 1 << NODE_W;

  // Parameter defaults
  localparam int unsigned NODES_DEF  = 1024;
  localparam int unsigned LEVELS_DEF = 10;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [ALU_W-1:0]  alu_t;

  // Item modes
  localparam mode_t MODE_LOAD  = 2'd0;
  localparam mode_t MODE_BUILD = 2'd1;
  localparam mode_t MODE_QUERY = 2'd2;

  // Store read kinds
  localparam logic RD_DEP  = 1'b0;
  localparam logic RD_JUMP = 1'b1;

  // Shared unit operations
  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    mode_t mode;
    node_t node;
    node_t other;
    node_t depth;
  } item_t;

  typedef struct packed {
    node_t ancestor;
    dist_t distance;
  } result_t;

  // Sequencer to store: one read and two write ports
  typedef struct packed {
    logic  rd_kind;
    node_t rd_node;
    logic  base_we;
    node_t base_node;
    node_t base_par;
    node_t base_dep;
    logic  up_we;
    node_t up_node;
    node_t up_val;
  } st_req_t;

  // Map node numbers outside the table onto the null node
  function automatic node_t node_idx(node_t v, int unsigned lim);
    return (32'(v) < lim) ? v : '0;
  endfunction

endpackage

`default_nettype wire

// ===== src/tree_distance_binary_lifting_core.sv =====
// Tree distance core: the host loads each node's parent and depth, issues a
// build to fill the jump levels, then queries pairs of nodes for their lowest
// common ancestor and edge distance. One transaction at a time: busy is high
// from the cycle after start is taken until the sequencer finishes, and the
// result appears on result_o with done_o for exactly one cycle, the first
// cycle in which busy is low again; the receiver cannot stall it, so capture
// it then. After reset the core sweeps the parent and depth tables to zero,
// one node per cycle, and stays busy until all min(NODES,1024) nodes are
// cleared. Every table read goes through one read port with a registered
// output. node_count is taken on the cfg channel at any time; write it
// while no transaction is in flight.
// ============================================================================
// tree_distance_binary_lifting_core: top level
// Configuration register, sequencer, table store and result register.
// ============================================================================
`default_nettype none

module tree_distance_binary_lifting_core #(
  parameter int unsigned NODES  = tdbl_pkg::NODES_DEF,
  parameter int unsigned LEVELS = tdbl_pkg::LEVELS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire tdbl_pkg::item_t   item_i,
  output logic                   done_o,
  output tdbl_pkg::result_t      result_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire tdbl_pkg::node_t   cfg_data_i
);
  import tdbl_pkg::*;

  localparam int unsigned LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  node_t     node_count_q;
  logic      done_q;
  result_t   result_q;

  logic      seq_done;
  result_t   seq_res;
  st_req_t   st_req;
  logic [LW-1:0] rd_lvl, up_lvl;
  node_t     fill, rd_data;

  // Node count register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= '1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      node_count_q <= cfg_data_i;
    end
  end

  tdbl_seq #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start && !busy),
    .item_i       (item_i),
    .node_count_i (node_count_q),
    .rd_data_i    (rd_data),
    .busy_o       (busy),
    .done_o       (seq_done),
    .res_o        (seq_res),
    .req_o        (st_req),
    .rd_lvl_o     (rd_lvl),
    .up_lvl_o     (up_lvl),
    .fill_o       (fill)
  );

  tdbl_store #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_store (
    .clk_i     (clk_i),
    .req_i     (st_req),
    .rd_lvl_i  (rd_lvl),
    .up_lvl_i  (up_lvl),
    .fill_i    (fill),
    .rd_data_o (rd_data)
  );

  // Register the result transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= seq_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_done) begin
      result_q <= seq_res;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // An accepted transaction always leaves the idle state
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // The sequencer finishes only while it holds a transaction
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_done |-> busy)
    else $error("result produced with no transaction in flight");

  // Results are single-cycle strobes, never back to back
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  // Distance cannot exceed the sum of two depths
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.distance != '1))
    else $error("distance out of range");

endmodule

`default_nettype wire

// ===== src/tdbl_alu.sv =====
// ============================================================================
// tdbl_alu: shared add/subtract and compare unit
// One 12-bit adder used by the sequencer for depth ordering, node equality
// checks, the depth sum and the final distance.
// ============================================================================
`default_nettype none

module tdbl_alu (
  input  wire logic           op_i,
  input  wire tdbl_pkg::alu_t x_i,
  input  wire tdbl_pkg::alu_t y_i,
  output tdbl_pkg::alu_t      res_o,
  output logic                zero_o,
  output logic                neg_o
);
  import tdbl_pkg::*;

  // Add or subtract; operands stay below 2^11 so the top bit is the sign
  always_comb begin
    if (op_i == ALU_SUB) begin
      res_o = x_i - y_i;
    end else begin
      res_o = x_i + y_i;
    end
    zero_o = (res_o == '0);
    neg_o  = res_o[ALU_W-1];
  end

endmodule

`default_nettype wire

// ===== src/tdbl_store.sv =====
// ============================================================================
// tdbl_store: parent, depth and jump level memories
// Level 0 and depth live in node-wide memories cleared by the sequencer;
// upper jump levels are gated by a fill count instead of being cleared.
// ============================================================================
`default_nettype none

module tdbl_store #(
  parameter  int unsigned NODES  = tdbl_pkg::NODES_DEF,
  parameter  int unsigned LEVELS = tdbl_pkg::LEVELS_DEF,
  localparam int unsigned LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
  input  wire logic              clk_i,
  input  wire tdbl_pkg::st_req_t req_i,
  input  wire logic [LW-1:0]     rd_lvl_i,
  input  wire logic [LW-1:0]     up_lvl_i,
  input  wire tdbl_pkg::node_t   fill_i,
  output tdbl_pkg::node_t        rd_data_o
);
  import tdbl_pkg::*;

  localparam int unsigned ENODES   = (NODES < NODE_MAX) ? NODES : NODE_MAX;
  localparam int unsigned AW       = $clog2(ENODES);
  localparam int unsigned UP_DEPTH = ENODES << LW;

  node_t par_mem [ENODES];
  node_t dep_mem [ENODES];
  node_t up_mem  [UP_DEPTH];

  node_t par_rd_q, dep_rd_q, up_rd_q;
  logic  kind_q, lvl0_q, zero_q;

  logic [AW-1:0] ra;
  assign ra = req_i.rd_node[AW-1:0];

  // Write level 0 and depth together (load and clear), upper levels on build
  always_ff @(posedge clk_i) begin
    if (req_i.base_we) begin
      par_mem[req_i.base_node[AW-1:0]] <= req_i.base_par;
      dep_mem[req_i.base_node[AW-1:0]] <= req_i.base_dep;
    end
    if (req_i.up_we) begin
      up_mem[{req_i.up_node[AW-1:0], up_lvl_i}] <= req_i.up_val;
    end
  end

  // Registered read of all three memories plus the select flags
  always_ff @(posedge clk_i) begin
    par_rd_q <= par_mem[ra];
    dep_rd_q <= dep_mem[ra];
    up_rd_q  <= up_mem[{ra, rd_lvl_i}];
    kind_q   <= req_i.rd_kind;
    lvl0_q   <= (rd_lvl_i == '0);
    zero_q   <= (req_i.rd_node == '0) || (req_i.rd_node > fill_i);
  end

  // Select the data; upper levels beyond the fill count read as null
  always_comb begin
    if (kind_q == RD_DEP) begin
      rd_data_o = dep_rd_q;
    end else if (lvl0_q) begin
      rd_data_o = node_idx(par_rd_q, ENODES);
    end else if (zero_q) begin
      rd_data_o = '0;
    end else begin
      rd_data_o = node_idx(up_rd_q, ENODES);
    end
  end

endmodule

`default_nettype wire

// ===== src/tdbl_seq.sv =====
// ============================================================================
// tdbl_seq: sequencer for load, build and query transactions
// Steps through table reads one at a time, driving the shared add/compare
// unit for ordering, equality tests and the distance.
// ============================================================================
`default_nettype none

module tdbl_seq #(
  parameter  int unsigned NODES  = tdbl_pkg::NODES_DEF,
  parameter  int unsigned LEVELS = tdbl_pkg::LEVELS_DEF,
  localparam int unsigned LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire tdbl_pkg::item_t   item_i,
  input  wire tdbl_pkg::node_t   node_count_i,
  input  wire tdbl_pkg::node_t   rd_data_i,
  output logic                   busy_o,
  output logic                   done_o,
  output tdbl_pkg::result_t      res_o,
  output tdbl_pkg::st_req_t      req_o,
  output logic [LW-1:0]          rd_lvl_o,
  output logic [LW-1:0]          up_lvl_o,
  output tdbl_pkg::node_t        fill_o
);
  import tdbl_pkg::*;

  localparam int unsigned ENODES = (NODES < NODE_MAX) ? NODES : NODE_MAX;
  localparam int unsigned AW     = $clog2(ENODES);
  localparam int unsigned SW     = 5;

  localparam logic [SW-1:0] ST_CLEAR = 5'd0;
  localparam logic [SW-1:0] ST_IDLE  = 5'd1;
  localparam logic [SW-1:0] ST_LOAD  = 5'd2;
  localparam logic [SW-1:0] ST_ZERO  = 5'd3;
  localparam logic [SW-1:0] ST_BINIT = 5'd4;
  localparam logic [SW-1:0] ST_B1    = 5'd5;
  localparam logic [SW-1:0] ST_B2    = 5'd6;
  localparam logic [SW-1:0] ST_B3    = 5'd7;
  localparam logic [SW-1:0] ST_QDX   = 5'd8;
  localparam logic [SW-1:0] ST_QDY   = 5'd9;
  localparam logic [SW-1:0] ST_QORD  = 5'd10;
  localparam logic [SW-1:0] ST_P1    = 5'd11;
  localparam logic [SW-1:0] ST_P1W   = 5'd12;
  localparam logic [SW-1:0] ST_EQ    = 5'd13;
  localparam logic [SW-1:0] ST_P2A   = 5'd14;
  localparam logic [SW-1:0] ST_P2B   = 5'd15;
  localparam logic [SW-1:0] ST_P2C   = 5'd16;
  localparam logic [SW-1:0] ST_FIN   = 5'd17;
  localparam logic [SW-1:0] ST_FINW  = 5'd18;
  localparam logic [SW-1:0] ST_DSUM  = 5'd19;
  localparam logic [SW-1:0] ST_DIST  = 5'd20;

  localparam logic [LW-1:0] LV_TOP = LW'(LEVELS - 1);

  // Control state
  logic [SW-1:0] state_q, state_d;
  logic [AW-1:0] i_q, i_d;
  logic [LW-1:0] lv_q, lv_d;
  node_t         fill_q, fill_d;

  // Working registers
  node_t             a_q, a_d, b_q, b_d, ua_q, ua_d, anc_q, anc_d, dep_q, dep_d;
  node_t             da_q, da_d, db_q, db_d;
  logic [LEVELS-1:0] d_q, d_d;
  logic [AW-1:0]     last_q, last_d;
  dist_t             sum_q, sum_d;

  // Shared unit hookup
  logic  alu_op, alu_zero, alu_neg;
  alu_t  alu_x, alu_y, alu_res;
  node_t absd, lim;

  tdbl_alu u_alu (
    .op_i   (alu_op),
    .x_i    (alu_x),
    .y_i    (alu_y),
    .res_o  (alu_res),
    .zero_o (alu_zero),
    .neg_o  (alu_neg)
  );

  assign busy_o   = (state_q != ST_IDLE);
  assign up_lvl_o = lv_q;
  assign fill_o   = fill_q;

  // Build covers nodes up to the smaller of node_count and the table top
  assign lim  = (32'(node_count_i) > ENODES - 1) ? NODE_W'(ENODES - 1) : node_count_i;
  // Magnitude of the depth difference from the subtraction
  assign absd = alu_neg ? NODE_W'(-alu_res) : NODE_W'(alu_res);

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    lv_d     = lv_q;
    fill_d   = fill_q;
    a_d      = a_q;
    b_d      = b_q;
    ua_d     = ua_q;
    anc_d    = anc_q;
    dep_d    = dep_q;
    da_d     = da_q;
    db_d     = db_q;
    d_d      = d_q;
    last_d   = last_q;
    sum_d    = sum_q;
    alu_op   = ALU_SUB;
    alu_x    = '0;
    alu_y    = '0;
    done_o   = 1'b0;
    res_o    = '0;
    req_o    = '0;
    rd_lvl_o = '0;

    unique case (state_q)
      // Sweep level 0 and depth to zero after reset
      ST_CLEAR: begin
        req_o.base_we   = 1'b1;
        req_o.base_node = NODE_W'(i_q);
        if (i_q == AW'(ENODES - 1)) begin
          state_d = ST_IDLE;
        end else begin
          i_d = i_q + AW'(1);
        end
      end

      // Take a transaction and dispatch on its mode
      ST_IDLE: begin
        if (start_i) begin
          a_d    = node_idx(item_i.node, ENODES);
          b_d    = (item_i.mode == MODE_LOAD) ? item_i.other
                                              : node_idx(item_i.other, ENODES);
          dep_d  = item_i.depth;
          last_d = lim[AW-1:0];
          unique case (item_i.mode)
            MODE_LOAD:  state_d = ST_LOAD;
            MODE_BUILD: state_d = ST_BINIT;
            MODE_QUERY: state_d = ST_QDX;
            default:    state_d = ST_ZERO;
          endcase
        end
      end

      // Store parent and depth; drop writes to the null node
      ST_LOAD: begin
        if (a_q != '0) begin
          req_o.base_we   = 1'b1;
          req_o.base_node = a_q;
          req_o.base_par  = b_q;
          req_o.base_dep  = dep_q;
        end
        state_d = ST_ZERO;
      end

      ST_ZERO: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end

      // Raise the fill count and start the level sweep
      ST_BINIT: begin
        if (NODE_W'(last_q) > fill_q) begin
          fill_d = NODE_W'(last_q);
        end
        lv_d = LW'(1);
        i_d  = AW'(1);
        if (LEVELS == 1 || last_q == '0) begin
          state_d = ST_ZERO;
        end else begin
          state_d = ST_B1;
        end
      end

      ST_B1: begin
        req_o.rd_kind = RD_JUMP;
        req_o.rd_node = NODE_W'(i_q);
        rd_lvl_o      = lv_q - LW'(1);
        state_d       = ST_B2;
      end

      ST_B2: begin
        req_o.rd_kind = RD_JUMP;
        req_o.rd_node = rd_data_i;
        rd_lvl_o      = lv_q - LW'(1);
        state_d       = ST_B3;
      end

      // Write the new jump and advance node, then level
      ST_B3: begin
        req_o.up_we   = 1'b1;
        req_o.up_node = NODE_W'(i_q);
        req_o.up_val  = rd_data_i;
        state_d       = ST_B1;
        if (i_q == last_q) begin
          i_d = AW'(1);
          if (lv_q == LV_TOP) begin
            state_d = ST_ZERO;
          end else begin
            lv_d = lv_q + LW'(1);
          end
        end else begin
          i_d = i_q + AW'(1);
        end
      end

      ST_QDX: begin
        req_o.rd_kind = RD_DEP;
        req_o.rd_node = a_q;
        state_d       = ST_QDY;
      end

      ST_QDY: begin
        da_d          = rd_data_i;
        req_o.rd_kind = RD_DEP;
        req_o.rd_node = b_q;
        state_d       = ST_QORD;
      end

      // Order the nodes so that a is the deeper one
      ST_QORD: begin
        alu_x = ALU_W'(da_q);
        alu_y = ALU_W'(rd_data_i);
        if (alu_neg) begin
          a_d  = b_q;
          b_d  = a_q;
          da_d = rd_data_i;
          db_d = da_q;
        end else begin
          db_d = rd_data_i;
        end
        d_d     = LEVELS'(absd);
        lv_d    = LV_TOP;
        state_d = ST_P1;
      end

      // Lift a by the set bits of the depth difference
      ST_P1: begin
        if (d_q[lv_q]) begin
          req_o.rd_kind = RD_JUMP;
          req_o.rd_node = a_q;
          rd_lvl_o      = lv_q;
          state_d       = ST_P1W;
        end else if (lv_q == '0) begin
          state_d = ST_EQ;
        end else begin
          lv_d = lv_q - LW'(1);
        end
      end

      ST_P1W: begin
        a_d = rd_data_i;
        if (lv_q == '0) begin
          state_d = ST_EQ;
        end else begin
          lv_d    = lv_q - LW'(1);
          state_d = ST_P1;
        end
      end

      // Same node after the first phase is the answer
      ST_EQ: begin
        alu_x         = ALU_W'(a_q);
        alu_y         = ALU_W'(b_q);
        req_o.rd_kind = RD_DEP;
        req_o.rd_node = a_q;
        anc_d         = a_q;
        if (alu_zero) begin
          state_d = ST_DSUM;
        end else begin
          lv_d    = LV_TOP;
          state_d = ST_P2A;
        end
      end

      ST_P2A: begin
        req_o.rd_kind = RD_JUMP;
        req_o.rd_node = a_q;
        rd_lvl_o      = lv_q;
        state_d       = ST_P2B;
      end

      ST_P2B: begin
        ua_d          = rd_data_i;
        req_o.rd_kind = RD_JUMP;
        req_o.rd_node = b_q;
        rd_lvl_o      = lv_q;
        state_d       = ST_P2C;
      end

      // Lift both nodes while their ancestors differ
      ST_P2C: begin
        alu_x = ALU_W'(ua_q);
        alu_y = ALU_W'(rd_data_i);
        if (!alu_zero) begin
          a_d = ua_q;
          b_d = rd_data_i;
        end
        if (lv_q == '0) begin
          state_d = ST_FIN;
        end else begin
          lv_d    = lv_q - LW'(1);
          state_d = ST_P2A;
        end
      end

      ST_FIN: begin
        req_o.rd_kind = RD_JUMP;
        req_o.rd_node = a_q;
        state_d       = ST_FINW;
      end

      ST_FINW: begin
        anc_d         = rd_data_i;
        req_o.rd_kind = RD_DEP;
        req_o.rd_node = rd_data_i;
        state_d       = ST_DSUM;
      end

      // Capture the ancestor depth and add the node depths
      ST_DSUM: begin
        dep_d   = rd_data_i;
        alu_op  = ALU_ADD;
        alu_x   = ALU_W'(da_q);
        alu_y   = ALU_W'(db_q);
        sum_d   = alu_res[DIST_W-1:0];
        state_d = ST_DIST;
      end

      // Subtract twice the ancestor depth, saturate at zero
      ST_DIST: begin
        alu_x          = ALU_W'(sum_q);
        alu_y          = ALU_W'({dep_q, 1'b0});
        done_o         = 1'b1;
        res_o.ancestor = anc_q;
        res_o.distance = alu_neg ? '0 : alu_res[DIST_W-1:0];
        state_d        = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      i_q     <= '0;
      lv_q    <= '0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      lv_q    <= lv_d;
      fill_q  <= fill_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    ua_q   <= ua_d;
    anc_q  <= anc_d;
    dep_q  <= dep_d;
    da_q   <= da_d;
    db_q   <= db_d;
    d_q    <= d_d;
    last_q <= last_d;
    sum_q  <= sum_d;
  end

endmodule

`default_nettype wire

// ===== verif/tb_tree_distance_binary_lifting_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tree distance core testbench
// Loads random rooted trees (one deep chain, several small forests), builds
// the jump table, and queries node pairs. A scoreboard with its own parent,
// jump and depth tables predicts each ancestor and distance and checks every
// done_o strobe against the oldest prediction. node_count is rewritten
// between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_tree_distance_binary_lifting_core;
  import tdbl_pkg::*;

  localparam int unsigned TB_NODES   = 1024;
  localparam int unsigned TB_LEVELS  = 10;
  localparam int unsigned CYCLE_CAP  = 1500000;
  localparam mode_t       MODE_UNUSED = 2'd3;

  // Predict lowest common ancestor and distance, check results in order
  class lca_checker;
    node_t       jump_tbl [TB_NODES][TB_LEVELS];
    node_t       depth_tbl [TB_NODES];
    node_t       node_limit;
    result_t     pending_results [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned n_load;
    int unsigned n_build;
    int unsigned n_query;
    int unsigned n_unused;

    function void clear();
      foreach (jump_tbl[i, j]) jump_tbl[i][j] = '0;
      foreach (depth_tbl[i]) depth_tbl[i] = '0;
      node_limit = 10'd1023;
      pending_results.delete();
      mismatches = 0;
      checked    = 0;
      n_load     = 0;
      n_build    = 0;
      n_query    = 0;
      n_unused   = 0;
    endfunction

    function void set_node_count(node_t v);
      node_limit = v;
    endfunction

    // Map out-of-table node numbers onto the null node
    function node_t clamp(int unsigned v);
      return (v < TB_NODES) ? node_t'(v) : '0;
    endfunction

    function node_t hop(node_t n, int unsigned lv);
      return clamp(jump_tbl[clamp(n)][lv]);
    endfunction

    function node_t lowest_ancestor(node_t a, node_t b);
      node_t       hi;
      node_t       lo;
      node_t       ua;
      node_t       ub;
      int unsigned diff;
      int          lv;
      if (depth_tbl[clamp(a)] < depth_tbl[clamp(b)]) begin
        hi = b;
        lo = a;
      end else begin
        hi = a;
        lo = b;
      end
      diff = depth_tbl[clamp(hi)] - depth_tbl[clamp(lo)];
      // Lift the deeper node by the depth difference
      for (lv = TB_LEVELS - 1; lv >= 0; lv--) begin
        if (lv < 32 && diff[lv]) hi = hop(hi, lv);
      end
      if (hi == lo) return hi;
      // Lift both while their ancestors differ
      for (lv = TB_LEVELS - 1; lv >= 0; lv--) begin
        ua = hop(hi, lv);
        ub = hop(lo, lv);
        if (ua != ub) begin
          hi = ua;
          lo = ub;
        end
      end
      return hop(hi, 0);
    endfunction

    function void predict_item(item_t it);
      result_t     exp_r;
      int unsigned last;
      int unsigned sum;
      int unsigned twice;
      node_t       x;
      node_t       y;
      node_t       mid;
      exp_r = '0;
      case (it.mode)
        MODE_LOAD: begin
          n_load++;
          if (it.node != 0 && it.node < TB_NODES) begin
            jump_tbl[it.node][0] = it.other;
            depth_tbl[it.node]   = it.depth;
          end
        end
        MODE_BUILD: begin
          n_build++;
          last = (node_limit > TB_NODES - 1) ? TB_NODES - 1 : node_limit;
          for (int unsigned j = 1; j < TB_LEVELS; j++) begin
            for (int unsigned i = 1; i <= last; i++) begin
              mid = hop(node_t'(i), j - 1);
              jump_tbl[i][j] = hop(mid, j - 1);
            end
          end
        end
        MODE_QUERY: begin
          n_query++;
          x = clamp(it.node);
          y = clamp(it.other);
          exp_r.ancestor = lowest_ancestor(x, y);
          sum   = depth_tbl[x] + depth_tbl[y];
          twice = 2 * depth_tbl[exp_r.ancestor];
          // Saturate when the tables are inconsistent
          exp_r.distance = (sum > twice) ? dist_t'(sum - twice) : '0;
        end
        default: begin
          n_unused++;
        end
      endcase
      pending_results.push_back(exp_r);
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: ancestor %0d distance %0d",
               got.ancestor, got.distance);
        mismatches++;
        return;
      end
      exp_r = pending_results.pop_front();
      checked++;
      if (got.ancestor !== exp_r.ancestor) begin
        $error("ancestor mismatch: expected %0d, actual %0d", exp_r.ancestor, got.ancestor);
        mismatches++;
      end
      if (got.distance !== exp_r.distance) begin
        $error("distance mismatch: expected %0d, actual %0d", exp_r.distance, got.distance);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  item_t       stim_item;
  logic        done_o;
  result_t     result_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  node_t       cfg_data_i;

  lca_checker  sb;
  bit          idle_on;
  bit          noise_on;
  int unsigned cycle_cnt;
  int unsigned cfg_writes;
  int unsigned max_depth;

  tree_distance_binary_lifting_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (stim_item),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock: 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Check every result transaction
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) sb.check_result(result_o);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_CAP) begin
      $error("timeout after %0d cycles, %0d results outstanding",
             cycle_cnt, sb.pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic item_t mk_item(mode_t m, node_t n, node_t o, node_t d);
    item_t it;
    it.mode  = m;
    it.node  = n;
    it.other = o;
    it.depth = d;
    return it;
  endfunction

  function automatic node_t rnd_node();
    return node_t'($urandom_range(0, 1023));
  endfunction

  // Present one item, optionally after a random gap, and hold it until taken
  task automatic issue_item(input item_t it);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 99) < 20) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    stim_item <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.predict_item(it);
  endtask

  // Hold off until every predicted result has arrived
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_node_count(input node_t v);
    drain_results();
    repeat ($urandom_range(2, 5)) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.set_node_count(v);
    cfg_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  // Random item of any mode, mixed into well-formed sequences
  task automatic maybe_noise();
    if (noise_on && $urandom_range(0, 99) < 10) begin
      issue_item(mk_item(mode_t'($urandom_range(0, 3)), rnd_node(), rnd_node(), rnd_node()));
    end
  endtask

  // Load a random tree, build, then query pairs drawn mostly from the tree
  task automatic run_tree_phase(input node_t nc, input int unsigned tree_size,
                                input int unsigned n_queries, input int unsigned chain_pct);
    node_t       ids [$];
    node_t       deps [$];
    bit          used [TB_NODES];
    int unsigned lim;
    int unsigned p;
    node_t       id;
    node_t       x;
    node_t       y;
    write_node_count(nc);
    lim = (nc >= tree_size) ? nc : 1023;
    foreach (used[i]) used[i] = 1'b0;
    // Loads: root first, then each node under an earlier one
    for (int unsigned k = 0; k < tree_size; k++) begin
      do id = node_t'($urandom_range(1, lim)); while (used[id]);
      used[id] = 1'b1;
      if (k == 0) begin
        ids.push_back(id);
        deps.push_back('0);
        issue_item(mk_item(MODE_LOAD, id, '0, '0));
      end else begin
        p = ($urandom_range(0, 99) < chain_pct) ? k - 1 : $urandom_range(0, k - 1);
        ids.push_back(id);
        deps.push_back(node_t'(deps[p] + 1));
        if (deps[p] + 1 > max_depth) max_depth = deps[p] + 1;
        issue_item(mk_item(MODE_LOAD, id, ids[p], deps[k]));
      end
      maybe_noise();
    end
    issue_item(mk_item(MODE_BUILD, rnd_node(), rnd_node(), rnd_node()));
    for (int unsigned q = 0; q < n_queries; q++) begin
      x = ($urandom_range(0, 99) < 85) ? ids[$urandom_range(0, ids.size() - 1)] : rnd_node();
      y = ($urandom_range(0, 99) < 85) ? ids[$urandom_range(0, ids.size() - 1)] : rnd_node();
      issue_item(mk_item(MODE_QUERY, x, y, rnd_node()));
      maybe_noise();
    end
  endtask

  initial begin
    node_t nc;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    stim_item   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    cycle_cnt   = 0;
    cfg_writes  = 0;
    max_depth   = 1023;
    idle_on     = 1'b1;
    noise_on    = 1'b0;
    sb = new;
    sb.clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: unused mode, null node load, small tree with a deep node,
    // inconsistent depths, then queries on the edges of the node range
    issue_item(mk_item(MODE_UNUSED, 10'd1023, 10'd1023, 10'd1023));
    issue_item(mk_item(MODE_LOAD, 10'd0, 10'd1023, 10'd1023));
    issue_item(mk_item(MODE_LOAD, 10'd1, 10'd0, 10'd0));
    issue_item(mk_item(MODE_LOAD, 10'd2, 10'd1, 10'd1));
    issue_item(mk_item(MODE_LOAD, 10'd3, 10'd1, 10'd1));
    issue_item(mk_item(MODE_LOAD, 10'd4, 10'd2, 10'd2));
    issue_item(mk_item(MODE_LOAD, 10'd1023, 10'd4, 10'd3));
    issue_item(mk_item(MODE_LOAD, 10'd5, 10'd1023, 10'd1023));
    issue_item(mk_item(MODE_LOAD, 10'd10, 10'd0, 10'd900));
    issue_item(mk_item(MODE_LOAD, 10'd9, 10'd10, 10'd1));
    issue_item(mk_item(MODE_LOAD, 10'd11, 10'd10, 10'd1));
    issue_item(mk_item(MODE_BUILD, 10'd1023, 10'd1023, 10'd1023));
    issue_item(mk_item(MODE_QUERY, 10'd4, 10'd3, 10'd0));
    issue_item(mk_item(MODE_QUERY, 10'd1023, 10'd3, 10'd0));
    issue_item(mk_item(MODE_QUERY, 10'd0, 10'd4, 10'd0));
    issue_item(mk_item(MODE_QUERY, 10'd4, 10'd4, 10'd0));
    issue_item(mk_item(MODE_QUERY, 10'd5, 10'd1, 10'd1023));
    issue_item(mk_item(MODE_QUERY, 10'd5, 10'd0, 10'd0));
    issue_item(mk_item(MODE_QUERY, 10'd1023, 10'd1023, 10'd0));
    issue_item(mk_item(MODE_QUERY, 10'd9, 10'd11, 10'd0));
    issue_item(mk_item(MODE_QUERY, 10'd0, 10'd0, 10'd0));
    issue_item(mk_item(MODE_QUERY, 10'd3, 10'd1023, 10'd0));
    issue_item(mk_item(MODE_UNUSED, 10'd0, 10'd0, 10'd0));
    max_depth = 0;

    // Deep, mostly chained tree back to back with no idling
    idle_on = 1'b0;
    run_tree_phase(10'd1023, 520, 60, 97);
    idle_on  = 1'b1;
    noise_on = 1'b1;

    // Small forests under a range of node counts, the extremes among them
    run_tree_phase(10'd1, 12, 20, 50);
    nc = node_t'($urandom_range(2, 60));
    run_tree_phase(nc, $urandom_range(2, nc), 25, 30);
    run_tree_phase(10'd1023, 30, 25, 60);
    run_tree_phase(node_t'($urandom_range(100, 300)), 40, 25, 40);
    nc = node_t'($urandom_range(20, 60));
    run_tree_phase(nc, 20, 20, 90);

    drain_results();
    repeat (20) @(posedge clk_i);
    $display("Run covered %0d loads, %0d builds, %0d queries and %0d unused-mode items;",
             sb.n_load, sb.n_build, sb.n_query, sb.n_unused);
    $display("%0d results checked over %0d node_count settings, deepest random tree %0d",
             sb.checked, cfg_writes, max_depth);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
